// File: hw/rtl/qnrcp_pkg.sv
// Shared types and constants for the QUIC NewReno congestion pacer.
package qnrcp_pkg;

	typedef enum logic [2:0] {
		OP_SENT    = 3'd0,
		OP_ACKED   = 3'd1,
		OP_LOST    = 3'd2,
		OP_PERSIST = 3'd3,
		OP_QUERY   = 3'd4,
		OP_RESET   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		REG_MDS  = 2'd0,
		REG_PRTT = 2'd1,
		REG_MINP = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic [63:0] ALL_ONES      = '1;
	localparam logic [15:0] MDS_RESET     = 16'd1200;
	localparam logic [31:0] PRTT_RESET    = 32'd3330000;
	localparam logic [31:0] MINP_RESET    = 32'd1000;
	localparam int          DIV_STEPS     = 64;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture input item
		logic mul;      // form dividend
		logic div_step; // one restoring-division step
		logic finish;   // commit state update
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_div; // item needs the divider
		logic div_last; // final division step in progress
	} dp_sts_t;

endpackage

// File: hw/rtl/qnrcp_ctrl.sv
// Sequencing state machine of the congestion pacer.
module qnrcp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output qnrcp_pkg::dp_cmd_t cmd,
	input  qnrcp_pkg::dp_sts_t sts
);
	import qnrcp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = sts.need_div ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_fin_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finish not followed by result");

endmodule

// File: hw/rtl/qnrcp_dp.sv
// Datapath: state registers, shared multiplier and iterative divider.
module qnrcp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  qnrcp_pkg::dp_cmd_t cmd,
	output qnrcp_pkg::dp_sts_t sts,
	input  logic [15:0]        mds,
	input  logic [31:0]        prtt,
	input  logic [31:0]        minp,
	input  logic [2:0]         opcode,
	input  logic [31:0]        byte_count,
	input  logic               counts_in_flight,
	input  logic [63:0]        now_time,
	input  logic [31:0]        smoothed_rtt,
	input  logic [63:0]        packet_sent_time,
	output logic               send_allowed,
	output logic [63:0]        window_bytes,
	output logic [63:0]        threshold_bytes,
	output logic [63:0]        in_flight_bytes,
	output logic [63:0]        next_send_time
);
	import qnrcp_pkg::*;

	logic [2:0]  op_q;
	logic [31:0] bytes_q;
	logic        flight_q;
	logic [63:0] now_q, sent_q;
	logic [31:0] rtt_q;
	logic [63:0] cwnd_q, ssth_q, bout_q, rec_q, dl_q;
	logic        allow_q;
	logic [63:0] quo_q, rem_q, dvd_q;
	logic [5:0]  cnt_q;

	// divider needed for sends and for acks outside recovery in congestion avoidance, nonzero window
	logic need_div;
	always_comb begin
		need_div = 1'b0;
		if (cwnd_q != '0) begin
			if (op_q == OP_SENT) begin
				need_div = 1'b1;
			end else if (op_q == OP_ACKED && sent_q > rec_q && !(cwnd_q < ssth_q)) begin
				need_div = 1'b1;
			end
		end
	end
	assign sts.need_div = need_div;
	assign sts.div_last = (cnt_q == 6'(DIV_STEPS - 1));

	// restoring division step
	logic [64:0] rem_sh, rem_sub;
	assign rem_sh  = {rem_q, dvd_q[63]};
	assign rem_sub = rem_sh - {1'b0, cwnd_q};

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL_ONES : s[63:0];
	endfunction

	logic [63:0] floor2, half, interval, base, inc;
	assign floor2 = {47'd0, mds, 1'b0};
	assign half   = cwnd_q >> 1;

	always_comb begin
		if (cwnd_q == '0) begin
			interval = {32'd0, rtt_q};
		end else begin
			interval = quo_q;
		end
		if (interval < {32'd0, minp}) begin
			interval = {32'd0, minp};
		end
		base = (dl_q > now_q) ? dl_q : now_q;
		inc  = (quo_q == '0 || cwnd_q == '0) ? 64'd1 : quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			bytes_q  <= byte_count;
			flight_q <= counts_in_flight;
			now_q    <= now_time;
			sent_q   <= packet_sent_time;
			rtt_q    <= (smoothed_rtt == '0) ? prtt : smoothed_rtt;
		end
		if (cmd.mul) begin
			dvd_q <= (op_q == OP_SENT) ? {32'd0, bytes_q} * {32'd0, rtt_q}
			                           : {48'd0, mds} * {32'd0, bytes_q};
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
			if (!rem_sub[64]) begin
				rem_q <= rem_sub[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q  <= 64'd10 * {48'd0, MDS_RESET};
			ssth_q  <= ALL_ONES;
			bout_q  <= '0;
			rec_q   <= '0;
			dl_q    <= '0;
			allow_q <= 1'b0;
		end else if (cmd.finish) begin
			allow_q <= 1'b0;
			case (op_q)
				OP_SENT: begin
					if (flight_q) begin
						bout_q <= sat_add(bout_q, {32'd0, bytes_q});
					end
					dl_q <= sat_add(base, interval);
				end
				OP_ACKED: begin
					bout_q <= ({32'd0, bytes_q} > bout_q) ? '0 : bout_q - {32'd0, bytes_q};
					if (sent_q > rec_q) begin
						if (cwnd_q < ssth_q) begin
							cwnd_q <= sat_add(cwnd_q, {32'd0, bytes_q});
						end else begin
							cwnd_q <= sat_add(cwnd_q, inc);
						end
					end
				end
				OP_LOST: begin
					bout_q <= ({32'd0, bytes_q} > bout_q) ? '0 : bout_q - {32'd0, bytes_q};
					if (now_q > rec_q) begin
						rec_q  <= now_q;
						cwnd_q <= (half < floor2) ? floor2 : half;
						ssth_q <= (half < floor2) ? floor2 : half;
					end
				end
				OP_PERSIST: begin
					cwnd_q <= floor2;
					ssth_q <= floor2;
				end
				OP_QUERY: begin
					allow_q <= !(bytes_q == '0 || {16'd0, bytes_q} > {32'd0, mds}
						|| bout_q > cwnd_q || {32'd0, bytes_q} > cwnd_q - bout_q
						|| now_q < dl_q);
				end
				OP_RESET: begin
					cwnd_q <= 64'd10 * {48'd0, mds};
					ssth_q <= ALL_ONES;
					bout_q <= '0;
					rec_q  <= '0;
					dl_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	assign send_allowed    = allow_q;
	assign window_bytes    = cwnd_q;
	assign threshold_bytes = ssth_q;
	assign in_flight_bytes = bout_q;
	assign next_send_time  = dl_q;

	a_div_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.load && !cmd.finish)
		else $error("divider step overlaps load or finish");
	a_allow_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && op_q != OP_QUERY |=> !send_allowed)
		else $error("send_allowed set outside query");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(cwnd_q) && $stable(dl_q))
		else $error("state changed without finish");

endmodule

// File: hw/rtl/quic_newreno_congestion_pacer.sv
// Top level of the QUIC NewReno congestion pacer: APB registers, controller and datapath.
// QUIC NewReno congestion controller with pacing. Each event transfer (sent, acked, lost,
// persistent congestion, send query, reset) yields exactly one result transfer carrying the
// query answer and the state after the event. Events are handled one at a time: an item
// goes from input transfer through the multiply state, the divide state when a pacing interval
// or congestion-avoidance increment is computed by the bit-serial 64-step restoring divider that
// divides by the congestion window, and the finish state to result valid. The result stays valid
// until taken; the next input transfer is accepted the cycle after. Registers at byte address 4*i:
// 0 max_datagram_size, 1 default_pacing_rtt, 2 min_pacing_interval; write them while idle.
module quic_newreno_congestion_pacer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] byte_count,
	input  logic        counts_in_flight,
	input  logic [63:0] now_time,
	input  logic [31:0] smoothed_rtt,
	input  logic [63:0] packet_sent_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_allowed,
	output logic [63:0] window_bytes,
	output logic [63:0] threshold_bytes,
	output logic [63:0] in_flight_bytes,
	output logic [63:0] next_send_time
);
	import qnrcp_pkg::*;

	logic [15:0] mds_q;
	logic [31:0] prtt_q, minp_q;
	logic        wr_en;
	logic [1:0]  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mds_q  <= MDS_RESET;
			prtt_q <= PRTT_RESET;
			minp_q <= MINP_RESET;
		end else if (wr_en && paddr[1:0] == 2'b00) begin
			case (reg_sel)
				REG_MDS:  mds_q  <= pwdata[15:0];
				REG_PRTT: prtt_q <= pwdata;
				REG_MINP: minp_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MDS:  prdata = {16'd0, mds_q};
			REG_PRTT: prdata = prtt_q;
			REG_MINP: prdata = minp_q;
			default:  prdata = '0;
		endcase
	end

	dp_cmd_t cmd;
	dp_sts_t sts;

	qnrcp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cmd(cmd), .sts(sts)
	);

	qnrcp_dp u_dp (
		.clk, .arst_n, .cmd(cmd), .sts(sts),
		.mds(mds_q), .prtt(prtt_q), .minp(minp_q),
		.opcode, .byte_count, .counts_in_flight, .now_time, .smoothed_rtt,
		.packet_sent_time, .send_allowed, .window_bytes, .threshold_bytes,
		.in_flight_bytes, .next_send_time
	);

endmodule
